FILE: rtl/core/shrp_pkg.sv
package shrp_pkg;

  // field and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 12;

  // defaults
  localparam int DEF_MAX_WIDTH = 2048;
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  // kernel centre weight
  localparam int SHARPEN_GAIN = 5;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  // up to two result items written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } out_push_t;

endpackage

FILE: rtl/core/shrp_stream_if.sv
interface shrp_in_if import shrp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface shrp_out_if import shrp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

FILE: rtl/core/shrp_line_buf.sv
module shrp_line_buf import shrp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_right,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]             wr_older,
  input  logic [PIX_W-1:0]             wr_newer,
  output logic [PIX_W-1:0]             older_q,
  output logic [PIX_W-1:0]             newer_q,
  output logic [PIX_W-1:0]             right_q
);

  // two rows back
  logic [PIX_W-1:0] row_store_older [MAX_WIDTH];
  // previous row, read at the column and the one to its right
  logic [PIX_W-1:0] row_store_newer [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_q <= row_store_older[rd_addr];
      newer_q <= row_store_newer[rd_addr];
      right_q <= row_store_newer[rd_addr_right];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_store_older[wr_addr] <= wr_older;
      row_store_newer[wr_addr] <= wr_newer;
    end
  end

endmodule

FILE: rtl/core/shrp_out_fifo.sv
module shrp_out_fifo import shrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  out_push_t            push,
  input  logic                 pop,
  output out_item_t            head,
  output logic [OUT_CNT_W-1:0] count
);

  out_item_t            slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_PTR_W-1:0] wr_ptr_second;

  assign wr_ptr_second = wr_ptr + OUT_PTR_W'(1);
  assign head          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
    end
  end

endmodule

FILE: rtl/core/sharpen_3x3_stream.sv
// 3x3 sharpen filter for 8-bit grayscale pixels in raster order: each interior
// output is five times the centre minus the left, right, upper and lower
// neighbours, clamped to 0..255; pixels in the first and last row and column
// come out as 0. The output for row r-1 leaves when the pixel of row r in the
// same column is taken, so the first row gives no output, the middle rows one
// item each, and each pixel of the last row gives two items: the one for the
// row above, then the zero of its own position, the very last carrying
// frame_end. Rate: one item per clock on all rows but the last while the queue
// has room; on the last row the output port sets the pace, as each pixel gives
// two results. Each result is registered at the line buffer read, then in the
// output queue. The two earlier rows live in a line buffer of MAX_WIDTH
// entries, read at the column and one to the right and written back in the
// next cycle; the left neighbour is kept in a register. frame_width is taken
// as 3..MAX_WIDTH and frame_height as at least 3. Configuration writes are to
// go in while the block is idle, which the block does not enforce, and act at
// once; a counter already past a new limit is treated as at its last index.
// Line buffer contents are not cleared by reset and need no clearing pass.
module sharpen_3x3_stream import shrp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  shrp_in_if.sink              pixels,
  shrp_out_if.source           sharpened
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LW    = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int SUM_W = 12;
  localparam logic signed [SUM_W-1:0] GAIN    = SUM_W'(SHARPEN_GAIN);
  localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'((1 << PIX_W) - 1);

  typedef struct packed {
    logic [CW-1:0]    col;
    logic [PIX_W-1:0] pixel;
    logic             emit;      // row above exists, one result due
    logic             interior;  // result is a filtered pixel, not a border zero
    logic             last_row;
    logic             last_col;
  } stage_t;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  // position counters
  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;

  // effective limits and clamped position of the incoming item
  logic [LW-1:0]    fw_ext;
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col_right;
  logic             last_col;
  logic             last_row;
  logic             accept;

  // read stage
  logic             s1_valid;
  stage_t           s1;
  logic [PIX_W-1:0] left;
  logic [PIX_W-1:0] older_q;
  logic [PIX_W-1:0] newer_q;
  logic [PIX_W-1:0] right_q;

  // kernel
  logic signed [SUM_W-1:0] cx;
  logic signed [SUM_W-1:0] lx;
  logic signed [SUM_W-1:0] rx;
  logic signed [SUM_W-1:0] ax;
  logic signed [SUM_W-1:0] bx;
  logic signed [SUM_W-1:0] sum;
  logic [PIX_W-1:0]        filtered;

  // output queue
  out_push_t            push;
  out_item_t            head;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]   q_need;
  logic                 pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // width clamped to 3..MAX_WIDTH, height raised to 3
  assign fw_ext = LW'(frame_width);

  always_comb begin
    if (fw_ext < LW'(3)) begin
      w_last = CW'(2);
    end else if (fw_ext > LW'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(fw_ext - LW'(1));
    end
  end

  assign h_last = (frame_height < ROW_W'(3)) ? ROW_W'(2) : frame_height - ROW_W'(1);

  assign col      = (column_count > w_last) ? w_last : column_count;
  assign row      = (row_count > h_last) ? h_last : row_count;
  assign last_col = (col == w_last);
  assign last_row = (row == h_last);

  // right neighbour address, held in range at the top entry (value unused there)
  assign col_right = (col == CW'(MAX_WIDTH - 1)) ? col : col + CW'(1);

  // room for this item's two possible results on top of what is in flight
  assign q_need        = (OUT_CNT_W + 1)'(q_count) + (OUT_CNT_W + 1)'(push.count)
                       + (OUT_CNT_W + 1)'(2);
  assign pixels.ready  = (q_need <= (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign accept        = pixels.valid & pixels.ready;

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        column_count <= col + CW'(1);
        row_count    <= row;
      end
    end
  end

  // line buffer: read on accept, move and write in the next cycle
  shrp_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk           (clk),
    .rd_en         (accept),
    .rd_addr       (col),
    .rd_addr_right (col_right),
    .wr_en         (s1_valid),
    .wr_addr       (s1.col),
    .wr_older      (newer_q),
    .wr_newer      (s1.pixel),
    .older_q       (older_q),
    .newer_q       (newer_q),
    .right_q       (right_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.col      <= col;
      s1.pixel    <= pixels.pixel_in;
      s1.emit     <= (row != '0);
      s1.interior <= (row > ROW_W'(1)) && (col != '0) && !last_col;
      s1.last_row <= last_row;
      s1.last_col <= last_col;
    end
  end

  // the centre row value just moved to the older store is the next item's left
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      left <= newer_q;
    end
  end

  // 5*centre - left - right - above - below, clamped
  assign cx  = SUM_W'(newer_q);
  assign lx  = SUM_W'(left);
  assign rx  = SUM_W'(right_q);
  assign ax  = SUM_W'(older_q);
  assign bx  = SUM_W'(s1.pixel);
  assign sum = GAIN * cx - lx - rx - ax - bx;

  always_comb begin
    if (sum < 0) begin
      filtered = '0;
    end else if (sum > PIX_MAX) begin
      filtered = '1;
    end else begin
      filtered = sum[PIX_W-1:0];
    end
  end

  // result for the row above first, then the last row's own zero
  always_comb begin
    push                  = '0;
    push.first.pixel_out  = s1.interior ? filtered : '0;
    push.first.frame_end  = 1'b0;
    push.second.pixel_out = '0;
    push.second.frame_end = s1.last_col;
    if (s1_valid) begin
      if (s1.emit && s1.last_row) begin
        push.count = 2'd2;
      end else if (s1.emit) begin
        push.count = 2'd1;
      end else if (s1.last_row) begin
        push.count = 2'd1;
        push.first = push.second;
      end
    end
  end

  shrp_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  assign sharpened.valid     = (q_count != '0);
  assign sharpened.pixel_out = head.pixel_out;
  assign sharpened.frame_end = head.frame_end;
  assign pop                 = sharpened.valid & sharpened.ready;

  // column stays inside the frame once an item moves it
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> column_count <= $past(w_last))
    else $error("column counter past frame width");

  // row stays inside the frame once an item moves it
  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> row_count <= $past(h_last))
    else $error("row counter past frame height");

  // the frame end falls on a border position, which is always zero
  a_frame_end_zero: assert property (@(posedge clk) disable iff (rst)
    sharpened.valid && sharpened.frame_end |-> sharpened.pixel_out == '0)
    else $error("frame end on a nonzero pixel");

  // output queue never overflows
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_count + OUT_CNT_W'(push.count) <= OUT_CNT_W'(OUT_DEPTH) + OUT_CNT_W'(pop))
    else $error("output queue overflow");

endmodule
